// ----- src/i2c_rb_pkg.sv -----
// Shared types, event codes and constants for the I2C target register bank.
`default_nettype none

package i2c_rb_pkg;

  // Bus event codes carried on the input beat.
  localparam logic [1:0] ACT_ADDR  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_STOP  = 2'd3;

  localparam int BANK_SIZE_DEFAULT = 16;

  localparam logic [7:0] PAST_END_BYTE = 8'hFF;
  localparam logic [8:0] COUNT_MAX     = 9'd256;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;      // An input beat is accepted this cycle.
    logic load_read;  // The bank read data is valid and goes to the output register.
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;    // The offered event is a byte request.
  } ctrl_stat_t;

  // Byte counts stop at 256.
  function automatic logic [8:0] count_next(input logic [8:0] c);
    logic [8:0] r;
    if (c >= COUNT_MAX) begin
      r = COUNT_MAX;
    end else begin
      r = c + 9'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/i2c_rb_ram.sv -----
// Generic single-port RAM with registered read data.
`default_nettype none

module i2c_rb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                         wdata,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- src/i2c_rb_datapath.sv -----
// Datapath: pointer, byte counts, register store with valid bits, and output register.
`default_nettype none

module i2c_rb_datapath #(
  parameter int BANK_SIZE = i2c_rb_pkg::BANK_SIZE_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire i2c_rb_pkg::ctrl_cmd_t  cmd,
  output i2c_rb_pkg::ctrl_stat_t      stat,
  input  wire logic [1:0]             action,
  input  wire logic [7:0]             rx_byte,
  output logic      [7:0]             tx_byte,
  output logic                        write_done,
  output logic                        dropped
);

  localparam int AW = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1;
  localparam logic [9:0] BANK_END = 10'(BANK_SIZE);

  logic [7:0]           reg_pointer;
  logic [8:0]           rx_count;
  logic [8:0]           tx_count;
  logic [BANK_SIZE-1:0] valid;
  logic                 rd_in_range;
  logic                 rd_valid;

  logic [9:0]    addr_rd;
  logic [9:0]    addr_wr;
  logic          rd_ok;
  logic          wr_ok;
  logic          is_write;
  logic          rx_first;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;

  assign addr_rd  = {2'b00, reg_pointer} + {1'b0, tx_count};
  assign addr_wr  = {2'b00, reg_pointer} + {1'b0, rx_count} - 10'd1;
  assign rd_ok    = addr_rd < BANK_END;
  assign wr_ok    = addr_wr < BANK_END;
  assign is_write = action == i2c_rb_pkg::ACT_WRITE;
  assign rx_first = rx_count == 9'd0;
  assign ram_we   = cmd.start && is_write && !rx_first && wr_ok;
  assign ram_addr = is_write ? addr_wr[AW-1:0] : addr_rd[AW-1:0];

  assign stat.is_read = action == i2c_rb_pkg::ACT_READ;

  i2c_rb_ram #(
    .WIDTH (8),
    .DEPTH (BANK_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (rx_byte),
    .rdata (ram_rdata)
  );

  // Bus state and the valid bits that stand in for the cleared store.
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_pointer <= 8'd0;
      rx_count    <= 9'd0;
      tx_count    <= 9'd0;
      valid       <= '0;
    end else if (cmd.start) begin
      unique case (action)
        i2c_rb_pkg::ACT_ADDR: begin
          rx_count <= 9'd0;
          tx_count <= 9'd0;
        end
        i2c_rb_pkg::ACT_READ: begin
          tx_count <= i2c_rb_pkg::count_next(tx_count);
        end
        i2c_rb_pkg::ACT_WRITE: begin
          if (rx_first) begin
            reg_pointer <= rx_byte;
          end
          if (ram_we) begin
            valid[ram_addr] <= 1'b1;
          end
          rx_count <= i2c_rb_pkg::count_next(rx_count);
        end
        default: begin
        end
      endcase
    end
  end

  // Output register, loaded at accept or, for a byte request, when the read returns.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_in_range <= rd_ok;
      rd_valid    <= valid[addr_rd[AW-1:0]];
      tx_byte     <= 8'd0;
      write_done  <= (action == i2c_rb_pkg::ACT_STOP) && !rx_first;
      dropped     <= is_write && !rx_first && !wr_ok;
    end else if (cmd.load_read) begin
      if (!rd_in_range) begin
        tx_byte <= i2c_rb_pkg::PAST_END_BYTE;
      end else if (rd_valid) begin
        tx_byte <= ram_rdata;
      end else begin
        tx_byte <= 8'd0;
      end
      write_done <= 1'b0;
      dropped    <= !rd_in_range;
    end
  end

endmodule

`default_nettype wire

// ----- src/i2c_rb_ctrl.sv -----
// Controller: accepts one event at a time and sequences the read and the output beat.
`default_nettype none

module i2c_rb_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  input  wire i2c_rb_pkg::ctrl_stat_t stat,
  output i2c_rb_pkg::ctrl_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready      = (state == S_IDLE) && !rst;
  assign out_valid     = state == S_OUT;
  assign cmd.start     = in_valid && in_ready;
  assign cmd.load_read = state == S_READ;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = stat.is_read ? S_READ : S_OUT;
        end
      end
      S_READ: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/i2c_target_register_bank.sv -----
// Top level of the I2C target register bank.
//
// Each input beat is one bus event from the I2C target front end, with the event code
// on s_tuser and the received byte on s_tdata. Address match clears the byte counts,
// the first received byte loads the register pointer, later received bytes are written
// at successive registers, and byte requests read successive registers (0xFF past the
// bank end). Stop reports whether any byte was received since the address match.
// Every event produces exactly one output beat on the m_ side.
//
// The block works on one event at a time. A beat is accepted only while the block is
// idle; its result appears in the next cycle, or for a byte request after a read state,
// because the register store has a registered read port.
// When the receiver stalls, the result holds steady in the output register and no new
// beat is accepted until it is taken.
//
// Reset (synchronous, active high) clears the pointer, both counts and the per-register
// valid bits, so every register reads as zero until written; no clearing pass is needed.
`default_nettype none

module i2c_target_register_bank #(
  parameter int BANK_SIZE = i2c_rb_pkg::BANK_SIZE_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  s_tuser,   // [1:0] action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata    // [7:0] tx_byte, [8] write_done, [9] dropped, rest zero
);

  i2c_rb_pkg::ctrl_cmd_t  cmd;
  i2c_rb_pkg::ctrl_stat_t stat;
  logic [7:0]             tx_byte;
  logic                   write_done;
  logic                   dropped;

  i2c_rb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  i2c_rb_datapath #(
    .BANK_SIZE (BANK_SIZE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .action     (s_tuser),
    .rx_byte    (s_tdata),
    .tx_byte    (tx_byte),
    .write_done (write_done),
    .dropped    (dropped)
  );

  // Output beat packing, first field in the lowest bits.
  assign m_tdata = {6'd0, dropped, write_done, tx_byte};

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the I2C target register bank: random bus events, shadow model.
`timescale 1ns / 1ps

// One output beat of the bank as it appears on m_tdata, lowest field last.
typedef struct packed {
  logic [5:0] pad;
  logic       dropped;
  logic       write_done;
  logic [7:0] tx_byte;
} bank_beat_t;

// Shadow copy of the register bank that predicts every output beat and
// checks the beats that come back, in order.
class register_bank_scoreboard;
  logic [7:0] shadow_regs [i2c_rb_pkg::BANK_SIZE_DEFAULT];
  logic [7:0] shadow_ptr;
  logic [8:0] rx_cnt;
  logic [8:0] tx_cnt;
  bank_beat_t pending_beats [$];
  int         errors;

  function new();
    foreach (shadow_regs[i]) shadow_regs[i] = 8'h00;
    shadow_ptr = 8'h00;
    rx_cnt     = 9'd0;
    tx_cnt     = 9'd0;
    errors     = 0;
  endfunction

  // Apply one accepted bus event to the shadow state and queue its beat.
  function void note_event(logic [1:0] act, logic [7:0] data);
    bank_beat_t exp_beat;
    logic [9:0] addr;
    exp_beat = '0;
    case (act)
      i2c_rb_pkg::ACT_ADDR: begin
        rx_cnt = 9'd0;
        tx_cnt = 9'd0;
      end
      i2c_rb_pkg::ACT_READ: begin
        addr = {2'b00, shadow_ptr} + {1'b0, tx_cnt};
        if (addr < i2c_rb_pkg::BANK_SIZE_DEFAULT) begin
          exp_beat.tx_byte = shadow_regs[addr];
        end else begin
          exp_beat.tx_byte = i2c_rb_pkg::PAST_END_BYTE;
          exp_beat.dropped = 1'b1;
        end
        if (tx_cnt < i2c_rb_pkg::COUNT_MAX) tx_cnt = tx_cnt + 9'd1;
      end
      i2c_rb_pkg::ACT_WRITE: begin
        if (rx_cnt == 9'd0) begin
          // The first byte of a transfer is the register pointer.
          shadow_ptr = data;
        end else begin
          addr = {2'b00, shadow_ptr} + {1'b0, rx_cnt} - 10'd1;
          if (addr < i2c_rb_pkg::BANK_SIZE_DEFAULT) begin
            shadow_regs[addr] = data;
          end else begin
            exp_beat.dropped = 1'b1;
          end
        end
        if (rx_cnt < i2c_rb_pkg::COUNT_MAX) rx_cnt = rx_cnt + 9'd1;
      end
      default: begin
        exp_beat.write_done = (rx_cnt != 9'd0);
      end
    endcase
    pending_beats.push_back(exp_beat);
  endfunction

  function void check_beat(logic [15:0] raw);
    bank_beat_t got;
    bank_beat_t want;
    got = raw;
    if (pending_beats.size() == 0) begin
      $display("%0t: unexpected beat, expected none, actual %04h", $time, raw);
      errors++;
      return;
    end
    want = pending_beats.pop_front();
    if (got.tx_byte !== want.tx_byte) begin
      $display("%0t: tx_byte expected %02h actual %02h", $time, want.tx_byte, got.tx_byte);
      errors++;
    end
    if (got.write_done !== want.write_done) begin
      $display("%0t: write_done expected %0b actual %0b", $time, want.write_done,
               got.write_done);
      errors++;
    end
    if (got.dropped !== want.dropped) begin
      $display("%0t: dropped expected %0b actual %0b", $time, want.dropped, got.dropped);
      errors++;
    end
    if (got.pad !== 6'd0) begin
      $display("%0t: padding bits expected 00 actual %02h", $time, got.pad);
      errors++;
    end
  endfunction

  function int pending_count();
    return pending_beats.size();
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic [1:0]  s_tuser = i2c_rb_pkg::ACT_ADDR;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  register_bank_scoreboard bank_sb = new();

  int         events_sent = 0;
  int         burst_left  = 0;
  int         ready_hold  = 0;
  logic [2:0] ready_phase = 3'd0;
  logic [7:0] ready_mask  = 8'hFF;

  i2c_target_register_bank #(
    .BANK_SIZE(i2c_rb_pkg::BANK_SIZE_DEFAULT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one event and hold it until the bank takes the beat. The sender
  // works in bursts; a gap of idle cycles may open before a new burst.
  task automatic send_event(input logic [1:0] act, input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    bank_sb.note_event(act, data);
    events_sent++;
  endtask

  // Pointers mostly land inside the bank or just past its end.
  function automatic logic [7:0] pick_pointer();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 8'($urandom_range(0, i2c_rb_pkg::BANK_SIZE_DEFAULT - 1));
    if (sel < 9) return 8'($urandom_range(0, i2c_rb_pkg::BANK_SIZE_DEFAULT + 6));
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver: checks every beat taken and stalls on a rotating mask that is
  // swapped at random intervals; an all-ones mask gives stretches of no stall.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) bank_sb.check_beat(m_tdata);
    if (ready_hold == 0) begin
      ready_hold = $urandom_range(16, 160);
      if ($urandom_range(0, 3) == 0) begin
        ready_mask = 8'hFF;
      end else begin
        ready_mask = 8'($urandom) | (8'h01 << $urandom_range(0, 7));
      end
    end
    ready_hold--;
    ready_phase = ready_phase + 3'd1;
    m_tready <= ready_mask[ready_phase];
  end

  initial begin
    int timeout_cycles;
    for (timeout_cycles = 0; timeout_cycles < CYCLE_LIMIT; timeout_cycles++) begin
      @(posedge clk);
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int kind;
    int n;
    bit long_runs_done;
    long_runs_done = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: events before any address match, a write run that walks off the
    // bank end, reads across the end, and the largest pointer.
    send_event(i2c_rb_pkg::ACT_READ,  8'h00);
    send_event(i2c_rb_pkg::ACT_STOP,  8'hFF);
    send_event(i2c_rb_pkg::ACT_WRITE, 8'h0D);
    send_event(i2c_rb_pkg::ACT_WRITE, 8'hFF);
    send_event(i2c_rb_pkg::ACT_ADDR,  8'h00);
    send_event(i2c_rb_pkg::ACT_WRITE, 8'h0E);
    send_event(i2c_rb_pkg::ACT_WRITE, 8'h00);
    send_event(i2c_rb_pkg::ACT_WRITE, 8'hFF);
    send_event(i2c_rb_pkg::ACT_WRITE, 8'hA5);
    send_event(i2c_rb_pkg::ACT_STOP,  8'h00);
    send_event(i2c_rb_pkg::ACT_ADDR,  8'hFF);
    send_event(i2c_rb_pkg::ACT_READ,  8'h00);
    send_event(i2c_rb_pkg::ACT_READ,  8'h00);
    send_event(i2c_rb_pkg::ACT_READ,  8'h00);
    send_event(i2c_rb_pkg::ACT_ADDR,  8'h00);
    send_event(i2c_rb_pkg::ACT_WRITE, 8'hFF);
    send_event(i2c_rb_pkg::ACT_WRITE, 8'h5A);
    send_event(i2c_rb_pkg::ACT_READ,  8'h00);
    send_event(i2c_rb_pkg::ACT_STOP,  8'h00);
    send_event(i2c_rb_pkg::ACT_ADDR,  8'h00);
    send_event(i2c_rb_pkg::ACT_STOP,  8'h00);

    while (events_sent < RANDOM_ITEMS) begin
      // Once, drive both counts into saturation with long runs.
      if (!long_runs_done && events_sent > 50) begin
        long_runs_done = 1'b1;
        send_event(i2c_rb_pkg::ACT_ADDR, 8'($urandom));
        send_event(i2c_rb_pkg::ACT_WRITE, 8'($urandom_range(0, 3)));
        n = $urandom_range(258, 262);
        repeat (n) send_event(i2c_rb_pkg::ACT_WRITE, 8'($urandom));
        send_event(i2c_rb_pkg::ACT_STOP, 8'($urandom));
        send_event(i2c_rb_pkg::ACT_ADDR, 8'($urandom));
        n = $urandom_range(258, 262);
        repeat (n) send_event(i2c_rb_pkg::ACT_READ, 8'($urandom));
        send_event(i2c_rb_pkg::ACT_STOP, 8'($urandom));
      end
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        // Register write transfer, now and then cut short without a stop.
        send_event(i2c_rb_pkg::ACT_ADDR, 8'($urandom));
        send_event(i2c_rb_pkg::ACT_WRITE, pick_pointer());
        n = $urandom_range(0, 8);
        repeat (n) send_event(i2c_rb_pkg::ACT_WRITE, 8'($urandom));
        if ($urandom_range(0, 7) != 0) send_event(i2c_rb_pkg::ACT_STOP, 8'($urandom));
      end else if (kind < 7) begin
        // Register read: usually pointer write, repeated start, then reads.
        send_event(i2c_rb_pkg::ACT_ADDR, 8'($urandom));
        if ($urandom_range(0, 2) != 0) begin
          send_event(i2c_rb_pkg::ACT_WRITE, pick_pointer());
          send_event(i2c_rb_pkg::ACT_ADDR, 8'($urandom));
        end
        n = $urandom_range(1, 8);
        repeat (n) send_event(i2c_rb_pkg::ACT_READ, 8'($urandom));
        send_event(i2c_rb_pkg::ACT_STOP, 8'($urandom));
      end else begin
        // Loose events in any order, with or without an address match.
        n = $urandom_range(1, 5);
        repeat (n) send_event(2'($urandom_range(0, 3)), 8'($urandom));
      end
    end
    s_tvalid <= 1'b0;

    while (bank_sb.pending_count() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (bank_sb.errors == 0 && bank_sb.pending_count() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
